// File: design/ebht_pkg.sv
// ebht_pkg: shared types and constants for the entropy block health test
// holds beat structs, fail reason codes, register indexes and map sizing
// no dependencies
package ebht_pkg;

  // byte value map: one entry per byte value
  localparam int unsigned MapDepth = 256;
  localparam int unsigned MapAddrW = 8;

  // block tag kept per map entry, zero means never marked
  localparam int unsigned EpochW = 8;
  localparam logic [EpochW-1:0] EpochNone  = '0;
  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [EpochW-1:0] EpochLast  = '1;

  // field widths
  localparam int unsigned RunW   = 8;
  localparam int unsigned DistW  = 9;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // register reset values
  localparam logic [RunW-1:0]  CutoffReset   = RunW'(8);
  localparam logic [DistW-1:0] DistMinReset  = DistW'(200);
  localparam logic [LenW-1:0]  MinLenReset   = LenW'(1000);
  localparam logic [DistW-1:0] DistFull      = DistW'(256);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCutoff  = 2'd0,
    CfgDistMin = 2'd1,
    CfgMinLen  = 2'd2,
    CfgNone    = 2'd3
  } cfg_idx_e;

  // fail reason codes
  typedef enum logic [1:0] {
    ReasonNone     = 2'd0,
    ReasonShort    = 2'd1,
    ReasonRepeat   = 2'd2,
    ReasonDistinct = 2'd3
  } reason_e;

  // input beat
  typedef struct packed {
    logic [7:0] sample_byte;
    logic       block_end;
  } sample_t;

  // result beat
  typedef struct packed {
    logic             block_pass;
    logic [1:0]       fail_reason;
    logic [DistW-1:0] distinct_seen;
  } result_t;

endpackage

// File: design/ebht_ram.sv
// ebht_ram: generic single write port, single read port ram with registered read
// read during write to the same address returns the old contents
// no dependencies
module ebht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/entropy_block_health_test.sv
// Entropy block health test. Takes one raw byte per cycle: the beat is accepted
// and its byte value map entry is read from the tag ram, and in the next cycle
// the run, length and distinct counters are updated and the entry written back,
// so a new byte can be accepted in every cycle. A beat with block_end set
// produces one result in the output register; it waits in the second stage only
// while an earlier result is still not taken. The map is cleared per block by
// tagging entries with a block number; a sweep clearing all 256 entries runs after
// reset and again after every 255 blocks, and no byte is accepted during it. The
// last byte of every 255th block also holds the input while it sits in the
// second stage, so the input pauses from that byte until the sweep has ended.
// Configuration writes are taken at any time.
// depends on ebht_pkg and ebht_ram
module entropy_block_health_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ebht_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ebht_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ebht_pkg::sample_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ebht_pkg::result_t             out_data_o
);
  import ebht_pkg::*;

  // configuration registers
  logic [RunW-1:0]  cutoff_q;
  logic [DistW-1:0] dist_min_q;
  logic [LenW-1:0]  min_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q   <= CutoffReset;
      dist_min_q <= DistMinReset;
      min_len_q  <= MinLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgCutoff:  cutoff_q   <= cfg_wdata_i[RunW-1:0];
        CfgDistMin: dist_min_q <= cfg_wdata_i[DistW-1:0];
        CfgMinLen:  min_len_q  <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // control and block state
  logic                s1_valid_q, s1_valid_d;
  logic                s1_end_q;
  logic [7:0]          s1_byte_q;
  logic                s1_fwd_q;
  logic [7:0]          prev_q, prev_d;
  logic [RunW-1:0]     run_q, run_d;
  logic                rep_q, rep_d;
  logic [DistW-1:0]    dist_q, dist_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [EpochW-1:0]   epoch_q, epoch_d;
  logic                sweep_q, sweep_d;
  logic [MapAddrW-1:0] sweep_cnt_q, sweep_cnt_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q, out_d;

  logic                in_acc;
  logic                s1_go;
  logic                s1_fire;
  logic                wrap_hold;
  logic                seen;
  logic                fwd_d;
  logic [EpochW-1:0]   tag_rdata;
  logic                ram_we;
  logic [MapAddrW-1:0] ram_waddr;
  logic [EpochW-1:0]   ram_wdata;
  logic [RunW-1:0]     run_n;
  logic                rep_n;
  logic [DistW-1:0]    dist_n;
  logic [LenW-1:0]     len_n;
  reason_e             reason;

  // handshake
  assign s1_go     = !(s1_end_q && out_valid_q && !out_ready_i);
  assign s1_fire   = s1_valid_q && s1_go;
  assign wrap_hold = s1_valid_q && s1_end_q && (epoch_q == EpochLast);
  assign in_ready_o = !sweep_q && !wrap_hold && (!s1_valid_q || s1_go);
  assign in_acc    = in_valid_i && in_ready_o;

  // tag ram: entry holds the block number that last marked the value
  ebht_ram #(
    .Width (EpochW),
    .Depth (MapDepth)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_data_i.sample_byte),
    .rdata_o (tag_rdata)
  );

  // write port: sweep clears, otherwise second stage marks the value
  always_comb begin
    if (sweep_q) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt_q;
      ram_wdata = EpochNone;
    end else begin
      ram_we    = s1_fire;
      ram_waddr = s1_byte_q;
      ram_wdata = epoch_q;
    end
  end

  // forward a mark written at the read edge, within the same block only
  assign fwd_d = s1_fire && !s1_end_q && (s1_byte_q == in_data_i.sample_byte);

  // first stage register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_data_i.sample_byte;
      s1_end_q  <= in_data_i.block_end;
      s1_fwd_q  <= fwd_d;
    end
  end

  // second stage: run, distinct and length update
  assign seen = s1_fwd_q || (tag_rdata == epoch_q);

  always_comb begin
    if ((run_q != '0) && (s1_byte_q == prev_q)) begin
      run_n = (run_q == '1) ? run_q : run_q + RunW'(1);
    end else begin
      run_n = RunW'(1);
    end
    rep_n  = rep_q || (run_n > cutoff_q);
    dist_n = (!seen && (dist_q < DistFull)) ? dist_q + DistW'(1) : dist_q;
    len_n  = (len_q == '1) ? len_q : len_q + LenW'(1);
    priority if (len_n < min_len_q) begin
      reason = ReasonShort;
    end else if (rep_n) begin
      reason = ReasonRepeat;
    end else if (dist_n < dist_min_q) begin
      reason = ReasonDistinct;
    end else begin
      reason = ReasonNone;
    end
  end

  // next state
  always_comb begin
    s1_valid_d  = in_acc ? 1'b1 : (s1_valid_q && !s1_go);
    prev_d      = prev_q;
    run_d       = run_q;
    rep_d       = rep_q;
    dist_d      = dist_q;
    len_d       = len_q;
    epoch_d     = epoch_q;
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    // clearing sweep
    if (sweep_q) begin
      sweep_cnt_d = sweep_cnt_q + MapAddrW'(1);
      if (sweep_cnt_q == '1) begin
        sweep_d = 1'b0;
        epoch_d = EpochFirst;
      end
    end

    if (s1_fire) begin
      if (s1_end_q) begin
        prev_d                = '0;
        run_d                 = '0;
        rep_d                 = 1'b0;
        dist_d                = '0;
        len_d                 = '0;
        out_valid_d           = 1'b1;
        out_d.block_pass      = (reason == ReasonNone);
        out_d.fail_reason     = reason;
        out_d.distinct_seen   = dist_n;
        if (epoch_q == EpochLast) begin
          sweep_d     = 1'b1;
          sweep_cnt_d = '0;
        end else begin
          epoch_d = epoch_q + EpochW'(1);
        end
      end else begin
        prev_d = s1_byte_q;
        run_d  = run_n;
        rep_d  = rep_n;
        dist_d = dist_n;
        len_d  = len_n;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      prev_q      <= '0;
      run_q       <= '0;
      rep_q       <= 1'b0;
      dist_q      <= '0;
      len_q       <= '0;
      epoch_q     <= EpochNone;
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      prev_q      <= prev_d;
      run_q       <= run_d;
      rep_q       <= rep_d;
      dist_q      <= dist_d;
      len_q       <= len_d;
      epoch_q     <= epoch_d;
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_q |-> !in_ready_o)
    else $error("beat accepted during map sweep");

  a_sweep_starts_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sweep_q) |-> !s1_valid_q)
    else $error("map sweep started with a byte in flight");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sweep_q) |-> (epoch_q != EpochNone))
    else $error("block tag zero outside sweep");

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_q <= DistFull)
    else $error("distinct count above 256");

  a_pass_matches_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.block_pass == (out_q.fail_reason == ReasonNone)))
    else $error("pass flag disagrees with fail reason");

endmodule
